FILE: hw/rtl/tcew_pkg.sv
`timescale 1ns / 1ps

package tcew_pkg;

	// default geometry
	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int MAX_HELD_DEF = 16;

	// cell values
	localparam logic [15:0] CLEARED_CELL = 16'h0F00;
	localparam logic [15:0] BLANK_CELL   = 16'h0020;
	localparam logic [15:0] ERASED_CELL  = 16'h0000;

	// colour reset values and limits
	localparam logic [3:0] FORE_RESET = 4'hF;
	localparam logic [2:0] BACK_RESET = 3'h0;
	localparam logic [7:0] FORE_MAX   = 8'd15;
	localparam logic [7:0] BACK_MAX   = 8'd7;

	// stream characters
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	// lead digit codes
	localparam logic [3:0] ATTR_RESET = 4'd0;
	localparam logic [3:0] ATTR_CLEAR = 4'd1;
	localparam logic [3:0] ATTR_BLINK = 4'd5;
	localparam logic [3:0] ATTR_ERASE = 4'd9;
	localparam logic [3:0] SEL_FORE   = 4'd3;
	localparam logic [3:0] SEL_BACK   = 4'd4;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  byte_in;
		logic        end_of_write;
		logic [10:0] cell_address;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_word;
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_line;
		logic        escape_pending;
	} result_t;

	typedef enum logic [9:0] {
		PH_IDLE = 10'b0000000001,
		PH_ESC  = 10'b0000000010,
		PH_BRK  = 10'b0000000100,
		PH_N1   = 10'b0000001000,
		PH_N1S  = 10'b0000010000,
		PH_N2   = 10'b0000100000,
		PH_N2S  = 10'b0001000000,
		PH_SEMI = 10'b0010000000,
		PH_Y    = 10'b0100000000,
		PH_YS   = 10'b1000000000
	} phase_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_M,
		FIN_COLOUR,
		FIN_CURSOR
	} fin_t;

	typedef struct packed {
		logic       ok;
		logic       hold;
		phase_t     phase;
		logic [7:0] first;
		logic [7:0] second;
		logic [3:0] lead;
		logic       tail;
		fin_t       fin;
	} parse_res_t;

	function automatic logic [7:0] sat_add(logic [7:0] v, logic [3:0] d);
		logic [11:0] t;
		t = 12'(v) * 12'd10 + 12'(d);
		return (t > 12'd255) ? 8'hFF : t[7:0];
	endfunction

endpackage

FILE: hw/rtl/tcew_ram.sv
`timescale 1ns / 1ps

module tcew_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/tcew_parse.sv
`timescale 1ns / 1ps

module tcew_parse (
	input  tcew_pkg::phase_t     phase,
	input  logic [7:0]           ch,
	input  logic [7:0]           first,
	input  logic [7:0]           second,
	input  logic [3:0]           lead,
	input  logic                 tail,
	output tcew_pkg::parse_res_t res
);

	logic       sp, dig, fin_ch;
	logic [3:0] d;
	logic [7:0] dd;

	always_comb begin
		sp     = (ch == tcew_pkg::CH_SPACE);
		dig    = (ch >= tcew_pkg::CH_0) && (ch <= tcew_pkg::CH_9);
		dd     = ch - tcew_pkg::CH_0;
		d      = dig ? dd[3:0] : 4'd0;
		fin_ch = (ch == tcew_pkg::CH_H) || (ch == tcew_pkg::CH_F);

		res.ok     = 1'b0;
		res.hold   = 1'b0;
		res.phase  = phase;
		res.first  = first;
		res.second = second;
		res.lead   = lead;
		res.tail   = tail;
		res.fin    = tcew_pkg::FIN_NONE;

		case (phase)
			tcew_pkg::PH_ESC: begin
				if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1;
				end else if (ch == tcew_pkg::CH_LBRK) begin
					res.ok = 1'b1; res.hold = 1'b1; res.phase = tcew_pkg::PH_BRK;
				end
			end
			tcew_pkg::PH_BRK: begin
				if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1;
				end else if (dig) begin
					res.ok     = 1'b1;
					res.hold   = 1'b1;
					res.phase  = tcew_pkg::PH_N1;
					res.lead   = d;
					res.first  = 8'(d);
					res.second = 8'd0;
					res.tail   = 1'b0;
				end
			end
			tcew_pkg::PH_N1: begin
				if (dig) begin
					res.ok     = 1'b1;
					res.hold   = 1'b1;
					res.first  = tcew_pkg::sat_add(first, d);
					res.second = tcew_pkg::sat_add(second, d);
					res.tail   = 1'b1;
				end else if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1; res.phase = tcew_pkg::PH_N1S;
				end else if (ch == tcew_pkg::CH_SEMI) begin
					res.ok = 1'b1; res.hold = 1'b1; res.phase = tcew_pkg::PH_SEMI;
				end else if (ch == tcew_pkg::CH_M) begin
					res.ok = 1'b1; res.phase = tcew_pkg::PH_IDLE; res.fin = tcew_pkg::FIN_M;
				end
			end
			tcew_pkg::PH_N1S: begin
				if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1;
				end else if (ch == tcew_pkg::CH_SEMI) begin
					res.ok = 1'b1; res.hold = 1'b1; res.phase = tcew_pkg::PH_SEMI;
				end else if (ch == tcew_pkg::CH_M) begin
					res.ok = 1'b1; res.phase = tcew_pkg::PH_IDLE; res.fin = tcew_pkg::FIN_M;
				end else if (dig && !tail) begin
					res.ok     = 1'b1;
					res.hold   = 1'b1;
					res.phase  = tcew_pkg::PH_N2;
					res.second = 8'(d);
				end
			end
			tcew_pkg::PH_N2: begin
				if (dig) begin
					res.ok = 1'b1; res.hold = 1'b1;
					res.second = tcew_pkg::sat_add(second, d);
				end else if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1; res.phase = tcew_pkg::PH_N2S;
				end else if (ch == tcew_pkg::CH_M) begin
					res.ok = 1'b1; res.phase = tcew_pkg::PH_IDLE;
					res.fin = tcew_pkg::FIN_COLOUR;
				end
			end
			tcew_pkg::PH_N2S: begin
				if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1;
				end else if (ch == tcew_pkg::CH_M) begin
					res.ok = 1'b1; res.phase = tcew_pkg::PH_IDLE;
					res.fin = tcew_pkg::FIN_COLOUR;
				end
			end
			tcew_pkg::PH_SEMI: begin
				if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1;
				end else if (dig) begin
					res.ok = 1'b1; res.hold = 1'b1; res.phase = tcew_pkg::PH_Y;
					res.second = 8'(d);
				end
			end
			tcew_pkg::PH_Y: begin
				if (dig) begin
					res.ok = 1'b1; res.hold = 1'b1;
					res.second = tcew_pkg::sat_add(second, d);
				end else if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1; res.phase = tcew_pkg::PH_YS;
				end else if (fin_ch) begin
					res.ok = 1'b1; res.phase = tcew_pkg::PH_IDLE;
					res.fin = tcew_pkg::FIN_CURSOR;
				end
			end
			tcew_pkg::PH_YS: begin
				if (sp) begin
					res.ok = 1'b1; res.hold = 1'b1;
				end else if (fin_ch) begin
					res.ok = 1'b1; res.phase = tcew_pkg::PH_IDLE;
					res.fin = tcew_pkg::FIN_CURSOR;
				end
			end
			default: begin
				res.ok = 1'b0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/text_console_escape_writer_core.sv
`timescale 1ns / 1ps
// text console with escape subset: one result item per input item
// plain printable byte: idle, feed; cell read: idle, rd; escape byte: idle, feed, next
// scroll walks the cell ram one cell a cycle, then blanks the last row
// clear screen writes every cell; replay reads each held byte, then puts it (read, put)
// after reset a clearing pass fills every cell of the cell ram before items are taken
// reset: cursor 0/0, colours white on black, parser idle, top bar off

module text_console_escape_writer_core #(
	parameter int COLUMNS  = tcew_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcew_pkg::ROWS_DEF,
	parameter int MAX_HELD = tcew_pkg::MAX_HELD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  tcew_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output tcew_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int CAW      = $clog2(CELLS);
	localparam int CSW      = CAW + 1;
	localparam int XW       = $clog2(COLUMNS);
	localparam int YW       = $clog2(ROWS);
	localparam int HAW      = $clog2(MAX_HELD);
	localparam int HCW      = $clog2(MAX_HELD + 1);
	localparam int LAST_ROW = (ROWS - 1) * COLUMNS;

	// sequencer: one-hot
	typedef enum logic [8:0] {
		ST_INIT   = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_FEED   = 9'b000000100,
		ST_RD     = 9'b000001000,
		ST_NEXT   = 9'b000010000,
		ST_RPL    = 9'b000100000,
		ST_SCROLL = 9'b001000000,
		ST_FILL   = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t              state_q, state_d;
	tcew_pkg::item_t     item_q, item_d;
	logic                top_q;
	logic [XW-1:0]       cur_x_q, cur_x_d;
	logic [YW-1:0]       cur_y_q, cur_y_d;
	logic [3:0]          fore_q, fore_d;
	logic [2:0]          back_q, back_d;
	logic                blink_q, blink_d;
	tcew_pkg::phase_t    phase_q, phase_d;
	logic [7:0]          first_q, first_d, second_q, second_d;
	logic [3:0]          lead_q, lead_d;
	logic                tail_q, tail_d;
	logic [HCW-1:0]      held_cnt_q, held_cnt_d;
	logic [HCW-1:0]      rp_i_q, rp_i_d, rp_n_q, rp_n_d;
	logic                fresh_q, fresh_d, eow_q, eow_d;
	logic [CSW-1:0]      scan_q, scan_d;
	logic                cp_s1, cp_d;
	logic [CAW-1:0]      cp_addr_s1, cp_addr_d;
	logic [CAW-1:0]      fill_q, fill_d;
	logic [15:0]         fill_val_q, fill_val_d;
	logic                rd_ok_q, rd_ok_d;
	logic [15:0]         word_q, word_d;
	tcew_pkg::result_t   res_q, res_d;
	logic                res_valid_q, res_valid_d;

	// cell ram ports
	logic                c_we;
	logic [CAW-1:0]      c_waddr, c_raddr;
	logic [15:0]         c_wdata, c_rdata;
	// held byte ram ports
	logic                h_we;
	logic [HAW-1:0]      h_waddr, h_raddr;
	logic [7:0]          h_wdata, h_rdata;

	tcew_pkg::parse_res_t pr;

	// put engine signals
	logic                put_go, fin;
	logic [7:0]          put_src;
	logic [XW:0]         px_inc;
	logic                px_wrap, py_last, is_nl, move_down, left_d;
	logic [31:0]         idx_full, addr_full;
	logic [CAW-1:0]      cur_idx;

	tcew_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cells (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	tcew_ram #(.WIDTH(8), .DEPTH(MAX_HELD)) u_held (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	tcew_parse u_parse (
		.phase  (phase_q),
		.ch     (item_q.byte_in),
		.first  (first_q),
		.second (second_q),
		.lead   (lead_q),
		.tail   (tail_q),
		.res    (pr)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		cur_x_d     = cur_x_q;
		cur_y_d     = cur_y_q;
		fore_d      = fore_q;
		back_d      = back_q;
		blink_d     = blink_q;
		phase_d     = phase_q;
		first_d     = first_q;
		second_d    = second_q;
		lead_d      = lead_q;
		tail_d      = tail_q;
		held_cnt_d  = held_cnt_q;
		rp_i_d      = rp_i_q;
		rp_n_d      = rp_n_q;
		fresh_d     = fresh_q;
		eow_d       = eow_q;
		scan_d      = scan_q;
		cp_d        = 1'b0;
		cp_addr_d   = cp_addr_s1;
		fill_d      = fill_q;
		fill_val_d  = fill_val_q;
		rd_ok_d     = rd_ok_q;
		word_d      = word_q;
		res_d       = res_q;
		res_valid_d = res_valid_q && result_stall;

		c_we    = 1'b0;
		c_waddr = '0;
		c_wdata = '0;
		c_raddr = '0;
		h_we    = 1'b0;
		h_waddr = held_cnt_q[HAW-1:0];
		h_wdata = item_q.byte_in;
		h_raddr = rp_i_q[HAW-1:0];
		put_go  = 1'b0;
		fin     = 1'b0;

		// cell under the cursor
		idx_full = 32'(cur_y_q) * COLUMNS + 32'(cur_x_q);
		cur_idx  = idx_full[CAW-1:0];
		addr_full = 32'(item.cell_address);

		case (state_q)
			ST_INIT: begin
				c_we    = 1'b1;
				c_waddr = fill_q;
				c_wdata = tcew_pkg::CLEARED_CELL;
				if (32'(fill_q) == CELLS - 1) begin
					state_d = ST_IDLE;
				end else begin
					fill_d = fill_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					item_d  = item;
					word_d  = '0;
					c_raddr = addr_full[CAW-1:0];
					rd_ok_d = (addr_full < CELLS);
					state_d = item.cmd ? ST_RD : ST_FEED;
				end
			end
			ST_RD: begin
				word_d = rd_ok_q ? c_rdata : 16'h0000;
				fin    = 1'b1;
			end
			ST_FEED: begin
				eow_d   = item_q.end_of_write;
				fresh_d = 1'b0;
				rp_i_d  = '0;
				rp_n_d  = '0;
				if (phase_q != tcew_pkg::PH_IDLE) begin
					state_d = ST_NEXT;
					if (held_cnt_q < HCW'(MAX_HELD) && pr.ok) begin
						phase_d  = pr.phase;
						first_d  = pr.first;
						second_d = pr.second;
						lead_d   = pr.lead;
						tail_d   = pr.tail;
						if (pr.hold) begin
							h_we       = 1'b1;
							held_cnt_d = held_cnt_q + 1'b1;
						end else begin
							held_cnt_d = '0;
						end
						// general attribute: only on m without digits after the lead
						if (pr.fin == tcew_pkg::FIN_M && !tail_q) begin
							case (lead_q)
								tcew_pkg::ATTR_RESET: begin
									fore_d  = tcew_pkg::FORE_RESET;
									back_d  = tcew_pkg::BACK_RESET;
									blink_d = 1'b0;
								end
								tcew_pkg::ATTR_CLEAR: begin
									cur_x_d    = '0;
									cur_y_d    = YW'(top_q);
									fore_d     = tcew_pkg::FORE_RESET;
									back_d     = tcew_pkg::BACK_RESET;
									blink_d    = 1'b0;
									fill_d     = '0;
									fill_val_d = tcew_pkg::CLEARED_CELL;
									state_d    = ST_FILL;
								end
								tcew_pkg::ATTR_BLINK: begin
									blink_d = 1'b1;
								end
								tcew_pkg::ATTR_ERASE: begin
									c_we    = 1'b1;
									c_waddr = cur_idx;
									c_wdata = tcew_pkg::ERASED_CELL;
								end
								default: begin
								end
							endcase
						end
						// colour select with a number
						if ((pr.fin == tcew_pkg::FIN_M && tail_q) ||
								pr.fin == tcew_pkg::FIN_COLOUR) begin
							if (lead_q == tcew_pkg::SEL_FORE && second_q <= tcew_pkg::FORE_MAX) begin
								fore_d = second_q[3:0];
							end
							if (lead_q == tcew_pkg::SEL_BACK && second_q <= tcew_pkg::BACK_MAX) begin
								back_d = second_q[2:0];
							end
						end
						// checked cursor move
						if (pr.fin == tcew_pkg::FIN_CURSOR) begin
							if (32'(first_q) < COLUMNS && 32'(second_q) >= 32'(top_q) &&
									32'(second_q) < ROWS) begin
								cur_x_d = XW'(first_q);
								cur_y_d = YW'(second_q);
							end
						end
					end else begin
						// bad or overlong: replay held bytes, then take this byte afresh
						rp_n_d     = held_cnt_q;
						phase_d    = tcew_pkg::PH_IDLE;
						held_cnt_d = '0;
						fresh_d    = 1'b1;
					end
				end else if (item_q.byte_in == tcew_pkg::CH_ESC) begin
					h_we       = 1'b1;
					held_cnt_d = HCW'(1);
					phase_d    = tcew_pkg::PH_ESC;
					state_d    = ST_NEXT;
				end else begin
					put_go = 1'b1;
				end
			end
			ST_NEXT: begin
				if (rp_i_q != rp_n_q) begin
					// fetch next held byte
					rp_i_d  = rp_i_q + 1'b1;
					state_d = ST_RPL;
				end else if (fresh_q) begin
					fresh_d = 1'b0;
					if (item_q.byte_in == tcew_pkg::CH_ESC) begin
						h_we       = 1'b1;
						h_waddr    = '0;
						held_cnt_d = HCW'(1);
						phase_d    = tcew_pkg::PH_ESC;
					end else begin
						put_go = 1'b1;
					end
				end else if (eow_q && phase_q != tcew_pkg::PH_IDLE) begin
					// cut-off sequence at end of write
					eow_d      = 1'b0;
					rp_i_d     = '0;
					rp_n_d     = held_cnt_q;
					phase_d    = tcew_pkg::PH_IDLE;
					held_cnt_d = '0;
				end else begin
					eow_d = 1'b0;
					fin   = 1'b1;
				end
			end
			ST_RPL: begin
				put_go = 1'b1;
			end
			ST_SCROLL: begin
				// read a cell below, write it one row up in the next cycle
				if (scan_q < CSW'(CELLS)) begin
					c_raddr   = scan_q[CAW-1:0];
					scan_d    = scan_q + 1'b1;
					cp_d      = 1'b1;
					cp_addr_d = CAW'(scan_q - CSW'(COLUMNS));
				end
				if (cp_s1) begin
					c_we    = 1'b1;
					c_waddr = cp_addr_s1;
					c_wdata = c_rdata;
				end
				if (scan_q == CSW'(CELLS) && !cp_s1) begin
					fill_d     = CAW'(LAST_ROW);
					fill_val_d = tcew_pkg::BLANK_CELL;
					state_d    = ST_FILL;
				end
			end
			ST_FILL: begin
				c_we    = 1'b1;
				c_waddr = fill_q;
				c_wdata = fill_val_q;
				if (32'(fill_q) == CELLS - 1) begin
					state_d = ST_NEXT;
				end else begin
					fill_d = fill_q + 1'b1;
				end
			end
			ST_DONE: begin
				fin = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// put one byte at the cursor
		case (state_q)
			ST_RPL:  put_src = h_rdata;
			default: put_src = item_q.byte_in;
		endcase
		is_nl     = (put_src == tcew_pkg::CH_NL);
		px_inc    = {1'b0, cur_x_q} + 1'b1;
		px_wrap   = (32'(px_inc) >= COLUMNS);
		py_last   = (32'(cur_y_q) + 32'd1 >= ROWS);
		move_down = is_nl || px_wrap;
		left_d    = (rp_i_d != rp_n_d) || fresh_d ||
			(eow_d && phase_d != tcew_pkg::PH_IDLE);
		if (put_go) begin
			if (is_nl) begin
				cur_x_d = '0;
			end else begin
				c_we    = 1'b1;
				c_waddr = cur_idx;
				c_wdata = {blink_q, back_q, fore_q, put_src};
				cur_x_d = px_wrap ? '0 : px_inc[XW-1:0];
			end
			if (move_down && py_last) begin
				scan_d  = top_q ? CSW'(2 * COLUMNS) : CSW'(COLUMNS);
				state_d = ST_SCROLL;
			end else begin
				if (move_down) begin
					cur_y_d = cur_y_q + 1'b1;
				end
				if (left_d) begin
					state_d = ST_NEXT;
				end else begin
					fin = 1'b1;
				end
			end
		end

		// result register: wait while an older result is still stalled
		if (fin) begin
			if (res_valid_q && result_stall) begin
				state_d = ST_DONE;
			end else begin
				res_d.cell_word      = word_d;
				res_d.cursor_column  = 7'(cur_x_d);
				res_d.cursor_line    = 5'(cur_y_d);
				res_d.escape_pending = (phase_d != tcew_pkg::PH_IDLE);
				res_valid_d          = 1'b1;
				state_d              = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			top_q       <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			fore_q      <= tcew_pkg::FORE_RESET;
			back_q      <= tcew_pkg::BACK_RESET;
			blink_q     <= 1'b0;
			phase_q     <= tcew_pkg::PH_IDLE;
			first_q     <= '0;
			second_q    <= '0;
			lead_q      <= '0;
			tail_q      <= 1'b0;
			held_cnt_q  <= '0;
			rp_i_q      <= '0;
			rp_n_q      <= '0;
			fresh_q     <= 1'b0;
			eow_q       <= 1'b0;
			scan_q      <= '0;
			cp_s1       <= 1'b0;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			if (cfg_valid && cfg_ready) begin
				top_q <= cfg_data;
			end
			cur_x_q     <= cur_x_d;
			cur_y_q     <= cur_y_d;
			fore_q      <= fore_d;
			back_q      <= back_d;
			blink_q     <= blink_d;
			phase_q     <= phase_d;
			first_q     <= first_d;
			second_q    <= second_d;
			lead_q      <= lead_d;
			tail_q      <= tail_d;
			held_cnt_q  <= held_cnt_d;
			rp_i_q      <= rp_i_d;
			rp_n_q      <= rp_n_d;
			fresh_q     <= fresh_d;
			eow_q       <= eow_d;
			scan_q      <= scan_d;
			cp_s1       <= cp_d;
			fill_q      <= fill_d;
			res_valid_q <= res_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		item_q     <= item_d;
		cp_addr_s1 <= cp_addr_d;
		fill_val_q <= fill_val_d;
		rd_ok_q    <= rd_ok_d;
		word_q     <= word_d;
		res_q      <= res_d;
	end

	// held store never overflows
	assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q <= HCW'(MAX_HELD))
		else $error("held count beyond limit");

	// a pending sequence always has its held bytes and vice versa
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != tcew_pkg::PH_IDLE) == (held_cnt_q != '0))
		else $error("parser phase and held count disagree");

	// cursor stays on screen
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_x_q) < COLUMNS && 32'(cur_y_q) < ROWS)
		else $error("cursor off screen");

	// scroll copies never land on the last row
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && cp_s1) |-> (32'(cp_addr_s1) < LAST_ROW))
		else $error("scroll copy into last row");

	// a replay never runs past what was held
	assert property (@(posedge clk) disable iff (!arst_n)
		rp_i_q <= rp_n_q)
		else $error("replay index past held count");

endmodule

FILE: sim/text_console_escape_writer_core_tb.sv
`timescale 1ns / 1ps

module text_console_escape_writer_core_tb;

	localparam int COLS  = 80;
	localparam int LINES = 25;
	localparam int HELD  = 16;
	localparam int CELLS = COLS * LINES;

	// one row of the directed stimulus table
	typedef struct {
		tcew_pkg::item_t   it;
		bit                fixed;
		tcew_pkg::result_t res;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	tcew_pkg::item_t   item;
	logic              result_valid;
	logic              result_stall;
	tcew_pkg::result_t result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_data;

	text_console_escape_writer_core #(
		.COLUMNS(COLS),
		.ROWS(LINES),
		.MAX_HELD(HELD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// predicted console state
	logic [15:0]       screen [0:CELLS-1];
	int                cur_x, cur_y;
	int                fore, back, blink;
	tcew_pkg::phase_t  phase;
	int                num_a, num_b, lead;
	bit                tail;
	logic [7:0]        held_q [HELD];
	int                held_n;
	bit                bar_on;

	tcew_pkg::result_t cursor_reports [$];
	stim_row_t         directed_rows [$];
	tcew_pkg::item_t   stream_q [$];
	tcew_pkg::result_t want;
	int                errors = 0;
	int                results_seen = 0;
	int                items_sent = 0;
	int                scrolls = 0;
	int                replays = 0;
	bit                long_hold_done = 0;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void console_reset();
		for (int i = 0; i < CELLS; i++) screen[i] = tcew_pkg::CLEARED_CELL;
		cur_x = 0;
		cur_y = 0;
		fore = 15;
		back = 0;
		blink = 0;
		phase = tcew_pkg::PH_IDLE;
		num_a = 0;
		num_b = 0;
		lead = 0;
		tail = 0;
		held_n = 0;
		bar_on = 0;
	endfunction

	function automatic void scroll_screen();
		scrolls++;
		for (int r = 1 + bar_on; r < LINES; r++)
			for (int c = 0; c < COLS; c++) screen[(r - 1) * COLS + c] = screen[r * COLS + c];
		for (int c = 0; c < COLS; c++) screen[(LINES - 1) * COLS + c] = tcew_pkg::BLANK_CELL;
	endfunction

	function automatic void line_feed();
		if (cur_y + 1 >= LINES) scroll_screen();
		else cur_y++;
	endfunction

	function automatic void print_char(logic [7:0] b);
		int idx;
		if (b == tcew_pkg::CH_NL) begin
			cur_x = 0;
			line_feed();
			return;
		end
		idx = cur_y * COLS + cur_x;
		if (idx < CELLS) screen[idx] = {blink[0], back[2:0], fore[3:0], b};
		cur_x++;
		if (cur_x >= COLS) begin
			cur_x = 0;
			line_feed();
		end
	endfunction

	// held bytes go out as plain text, esc first
	function automatic void flush_held();
		logic [7:0] copy [HELD];
		int n;
		n = held_n;
		for (int i = 0; i < n; i++) copy[i] = held_q[i];
		phase = tcew_pkg::PH_IDLE;
		held_n = 0;
		replays++;
		for (int i = 0; i < n; i++) print_char(copy[i]);
	endfunction

	function automatic int clamp_decimal(int v, int d);
		v = v * 10 + d;
		return (v > 255) ? 255 : v;
	endfunction

	function automatic void set_colour(int sel, int v);
		if (sel == tcew_pkg::SEL_FORE && v <= 15) fore = v;
		else if (sel == tcew_pkg::SEL_BACK && v <= 7) back = v;
	endfunction

	function automatic void run_attr(int n);
		if (n == tcew_pkg::ATTR_RESET) begin
			fore = 15; back = 0; blink = 0;
		end else if (n == tcew_pkg::ATTR_CLEAR) begin
			cur_x = 0;
			cur_y = bar_on;
			fore = 15; back = 0; blink = 0;
			for (int i = 0; i < CELLS; i++) screen[i] = tcew_pkg::CLEARED_CELL;
		end else if (n == tcew_pkg::ATTR_BLINK) begin
			blink = 1;
		end else if (n == tcew_pkg::ATTR_ERASE) begin
			if (cur_y * COLS + cur_x < CELLS)
				screen[cur_y * COLS + cur_x] = tcew_pkg::ERASED_CELL;
		end
	endfunction

	function automatic bit keep(logic [7:0] b, tcew_pkg::phase_t nxt);
		held_q[held_n] = b;
		held_n++;
		phase = nxt;
		return 1;
	endfunction

	function automatic void close_seq();
		phase = tcew_pkg::PH_IDLE;
		held_n = 0;
	endfunction

	// one byte into a pending sequence, 0 when it breaks the grammar
	function automatic bit parse_byte(logic [7:0] b);
		bit sp, dig, fin;
		int d;
		sp = (b == tcew_pkg::CH_SPACE);
		dig = (b >= tcew_pkg::CH_0 && b <= tcew_pkg::CH_9);
		d = dig ? int'(b - tcew_pkg::CH_0) : 0;
		fin = (b == tcew_pkg::CH_H || b == tcew_pkg::CH_F);
		case (phase)
			tcew_pkg::PH_ESC: begin
				if (sp) return keep(b, tcew_pkg::PH_ESC);
				if (b == tcew_pkg::CH_LBRK) return keep(b, tcew_pkg::PH_BRK);
			end
			tcew_pkg::PH_BRK: begin
				if (sp) return keep(b, tcew_pkg::PH_BRK);
				if (dig) begin
					lead = d; num_a = d; num_b = 0; tail = 0;
					return keep(b, tcew_pkg::PH_N1);
				end
			end
			tcew_pkg::PH_N1: begin
				if (dig) begin
					num_a = clamp_decimal(num_a, d);
					num_b = clamp_decimal(num_b, d);
					tail = 1;
					return keep(b, tcew_pkg::PH_N1);
				end
				if (sp) return keep(b, tcew_pkg::PH_N1S);
				if (b == tcew_pkg::CH_SEMI) return keep(b, tcew_pkg::PH_SEMI);
				if (b == tcew_pkg::CH_M) begin
					close_seq();
					if (tail) set_colour(lead, num_b);
					else run_attr(lead);
					return 1;
				end
			end
			tcew_pkg::PH_N1S: begin
				if (sp) return keep(b, tcew_pkg::PH_N1S);
				if (b == tcew_pkg::CH_SEMI) return keep(b, tcew_pkg::PH_SEMI);
				if (b == tcew_pkg::CH_M) begin
					close_seq();
					if (tail) set_colour(lead, num_b);
					else run_attr(lead);
					return 1;
				end
				if (dig && !tail) begin
					num_b = d;
					return keep(b, tcew_pkg::PH_N2);
				end
			end
			tcew_pkg::PH_N2: begin
				if (dig) begin
					num_b = clamp_decimal(num_b, d);
					return keep(b, tcew_pkg::PH_N2);
				end
				if (sp) return keep(b, tcew_pkg::PH_N2S);
				if (b == tcew_pkg::CH_M) begin
					close_seq();
					set_colour(lead, num_b);
					return 1;
				end
			end
			tcew_pkg::PH_N2S: begin
				if (sp) return keep(b, tcew_pkg::PH_N2S);
				if (b == tcew_pkg::CH_M) begin
					close_seq();
					set_colour(lead, num_b);
					return 1;
				end
			end
			tcew_pkg::PH_SEMI: begin
				if (sp) return keep(b, tcew_pkg::PH_SEMI);
				if (dig) begin
					num_b = d;
					return keep(b, tcew_pkg::PH_Y);
				end
			end
			tcew_pkg::PH_Y, tcew_pkg::PH_YS: begin
				if (dig && phase == tcew_pkg::PH_Y) begin
					num_b = clamp_decimal(num_b, d);
					return keep(b, tcew_pkg::PH_Y);
				end
				if (sp) return keep(b, tcew_pkg::PH_YS);
				if (fin) begin
					close_seq();
					if (num_a < COLS && num_b >= bar_on && num_b < LINES) begin
						cur_x = num_a;
						cur_y = num_b;
					end
					return 1;
				end
			end
			default: ;
		endcase
		return 0;
	endfunction

	function automatic void feed_byte(logic [7:0] b);
		if (phase != tcew_pkg::PH_IDLE) begin
			if (held_n < HELD && parse_byte(b)) return;
			flush_held();
		end
		if (b == tcew_pkg::CH_ESC) begin
			held_q[0] = b;
			held_n = 1;
			phase = tcew_pkg::PH_ESC;
		end else begin
			print_char(b);
		end
	endfunction

	function automatic tcew_pkg::result_t console_step(tcew_pkg::item_t it);
		tcew_pkg::result_t r;
		r.cell_word = '0;
		if (it.cmd) begin
			if (it.cell_address < CELLS) r.cell_word = screen[it.cell_address];
		end else begin
			feed_byte(it.byte_in);
			if (it.end_of_write && phase != tcew_pkg::PH_IDLE) flush_held();
		end
		r.cursor_column = cur_x[6:0];
		r.cursor_line = cur_y[4:0];
		r.escape_pending = (phase != tcew_pkg::PH_IDLE);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic tcew_pkg::item_t wr(logic [7:0] b, bit eow);
		tcew_pkg::item_t it;
		it.cmd = 1'b0;
		it.byte_in = b;
		it.end_of_write = eow;
		it.cell_address = 11'($urandom_range(0, 2047));
		return it;
	endfunction

	function automatic tcew_pkg::item_t rd(int addr);
		tcew_pkg::item_t it;
		it.cmd = 1'b1;
		it.byte_in = 8'($urandom_range(0, 255));
		it.end_of_write = 1'($urandom_range(0, 1));
		it.cell_address = 11'(addr);
		return it;
	endfunction

	function automatic void add_row(tcew_pkg::item_t it, bit fixed, logic [15:0] w,
			int x, int y, bit p);
		stim_row_t row;
		row.it = it;
		row.fixed = fixed;
		row.res = '{cell_word: w, cursor_column: 7'(x), cursor_line: 5'(y), escape_pending: p};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_bytes(ref logic [7:0] q [$], input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
	endfunction

	function automatic void add_pad(ref logic [7:0] q [$]);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) q.push_back(tcew_pkg::CH_SPACE);
	endfunction

	function automatic int pick_num(int lo, int hi);
		// mostly in range, sometimes far past it so the count saturates
		if ($urandom_range(0, 9) == 0) return $urandom_range(256, 9999);
		return $urandom_range(lo, hi);
	endfunction

	// one well-formed escape sequence with random content
	function automatic void make_sequence(ref logic [7:0] q [$]);
		int kind;
		kind = $urandom_range(0, 5);
		q.push_back(tcew_pkg::CH_ESC);
		add_pad(q);
		q.push_back(tcew_pkg::CH_LBRK);
		add_pad(q);
		case (kind)
			0, 1: begin
				add_bytes(q, $sformatf("%0d", pick_num(0, 85)));
				add_pad(q);
				q.push_back(tcew_pkg::CH_SEMI);
				add_pad(q);
				add_bytes(q, $sformatf("%0d", pick_num(0, 27)));
				add_pad(q);
				q.push_back($urandom_range(0, 1) ? tcew_pkg::CH_H : tcew_pkg::CH_F);
			end
			2: begin
				// clear is slow, keep it rare
				int d;
				d = $urandom_range(0, 9);
				if (d == tcew_pkg::ATTR_CLEAR && $urandom_range(0, 3) != 0)
					d = tcew_pkg::ATTR_BLINK;
				q.push_back(8'(tcew_pkg::CH_0 + d));
				add_pad(q);
				q.push_back(tcew_pkg::CH_M);
			end
			default: begin
				int sel;
				sel = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) :
					($urandom_range(0, 1) ? tcew_pkg::SEL_FORE : tcew_pkg::SEL_BACK);
				q.push_back(8'(tcew_pkg::CH_0 + sel));
				if ($urandom_range(0, 1)) q.push_back(tcew_pkg::CH_SPACE);
				add_bytes(q, $sformatf("%0d", pick_num(0, 18)));
				add_pad(q);
				q.push_back(tcew_pkg::CH_M);
			end
		endcase
	endfunction

	// builds a random stretch of write and read items
	task automatic build_phase(int count);
		logic [7:0] bytes [$];
		bit eow_last;
		int kind, cut;
		while (stream_q.size() < count) begin
			bytes.delete();
			eow_last = 0;
			kind = $urandom_range(0, 19);
			if (kind < 10) begin
				make_sequence(bytes);
			end else if (kind < 14) begin
				// broken: cut a good sequence short and add a stray byte
				make_sequence(bytes);
				cut = $urandom_range(1, bytes.size() - 1);
				while (bytes.size() > cut) void'(bytes.pop_back());
				bytes.push_back(($urandom_range(0, 2) == 0) ? tcew_pkg::CH_ESC :
					8'($urandom_range(0, 255)));
			end else if (kind == 14) begin
				// cut off by the end of the write call
				make_sequence(bytes);
				cut = $urandom_range(1, bytes.size() - 1);
				while (bytes.size() > cut) void'(bytes.pop_back());
				eow_last = 1;
			end else if (kind == 15) begin
				// too long before the final byte
				bytes.push_back(tcew_pkg::CH_ESC);
				repeat ($urandom_range(HELD - 2, HELD + 3)) bytes.push_back(tcew_pkg::CH_SPACE);
				add_bytes(bytes, "[3m");
			end else begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 14) == 0) bytes.push_back(tcew_pkg::CH_NL);
					else if ($urandom_range(0, 5) == 0) bytes.push_back(8'($urandom_range(0, 255)));
					else bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
				end
			end
			for (int i = 0; i < bytes.size(); i++) begin
				if ($urandom_range(0, 9) == 0)
					stream_q.push_back(rd(($urandom_range(0, 9) == 0) ?
						$urandom_range(0, 2047) : $urandom_range(0, CELLS - 1)));
				stream_q.push_back(wr(bytes[i],
					(i == bytes.size() - 1) ? (eow_last | ($urandom_range(0, 9) == 0)) : 1'b0));
			end
		end
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// stretches of items with no idling at all
	function automatic bit quiet_stretch(int n);
		return ((n / 64) % 3) == 0;
	endfunction

	// one item, held until accepted
	task automatic send_item(tcew_pkg::item_t it, bit fixed, tcew_pkg::result_t fixed_res);
		tcew_pkg::result_t r;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		r = console_step(it);
		cursor_reports.push_back(fixed ? fixed_res : r);
		items_sent++;
		if (!quiet_stretch(items_sent) && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (cursor_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_top_bar(bit v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		bar_on = v;
	endtask

	task automatic run_stream();
		while (stream_q.size() != 0) begin
			// once, let everything drain before going on
			if (items_sent == 300) wait_drained();
			send_item(stream_q.pop_front(), 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// clock, reset, limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: random stall, one long hold to back the block up
	// ------------------------------------------------------------------
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen >= 120 && !long_hold_done) begin
				long_hold_done = 1;
				result_stall <= 1'b1;
				repeat (600) @(posedge clk);
			end else if (!quiet_stretch(results_seen) && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat (pick_gap()) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// result checker against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (cursor_reports.size() == 0) begin
				$error("result item with nothing expected: %h", result);
				errors++;
			end else begin
				want = cursor_reports.pop_front();
				if (result.cell_word !== want.cell_word) begin
					$error("cell_word expected %h got %h", want.cell_word, result.cell_word);
					errors++;
				end
				if (result.cursor_column !== want.cursor_column) begin
					$error("cursor_column expected %0d got %0d",
						want.cursor_column, result.cursor_column);
					errors++;
				end
				if (result.cursor_line !== want.cursor_line) begin
					$error("cursor_line expected %0d got %0d",
						want.cursor_line, result.cursor_line);
					errors++;
				end
				if (result.escape_pending !== want.escape_pending) begin
					$error("escape_pending expected %0d got %0d",
						want.escape_pending, result.escape_pending);
					errors++;
				end
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// sender: directed table, then random phases under each top bar value
	// ------------------------------------------------------------------
	initial begin
		int waited;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		console_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// after reset: cleared cells, cursor home; out of range reads 0
		add_row(rd(0), 1, tcew_pkg::CLEARED_CELL, 0, 0, 0);
		add_row(rd(2047), 1, tcew_pkg::ERASED_CELL, 0, 0, 0);
		add_row(rd(CELLS - 1), 1, tcew_pkg::CLEARED_CELL, 0, 0, 0);
		add_row(wr("A", 0), 0, 0, 0, 0, 0);
		add_row(wr(8'hFF, 1), 0, 0, 0, 0, 0);
		// fore colour, then erase cell at cursor
		add_row(wr(tcew_pkg::CH_ESC, 0), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_LBRK, 0), 0, 0, 0, 0, 0);
		add_row(wr("3", 0), 0, 0, 0, 0, 0);
		add_row(wr("1", 0), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_M, 0), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_ESC, 0), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_LBRK, 0), 0, 0, 0, 0, 0);
		add_row(wr("9", 0), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_M, 0), 0, 0, 0, 0, 0);
		// bad sequence replayed as text
		add_row(wr(tcew_pkg::CH_ESC, 0), 0, 0, 0, 0, 0);
		add_row(wr("x", 0), 0, 0, 0, 0, 0);
		// sequence cut off by end of write
		add_row(wr(tcew_pkg::CH_ESC, 0), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_LBRK, 1), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_NL, 0), 0, 0, 0, 0, 0);
		add_row(rd(COLS + 1), 0, 0, 0, 0, 0);
		// clear screen
		add_row(wr(tcew_pkg::CH_ESC, 0), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_LBRK, 0), 0, 0, 0, 0, 0);
		add_row(wr("1", 0), 0, 0, 0, 0, 0);
		add_row(wr(tcew_pkg::CH_M, 0), 0, 0, 0, 0, 0);
		foreach (directed_rows[i])
			send_item(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].res);
		wait_drained();

		write_top_bar(1'b1);
		build_phase(150);
		run_stream();
		wait_drained();

		write_top_bar(1'b0);
		build_phase(150);
		run_stream();
		wait_drained();

		write_top_bar(1'b1);
		build_phase(150);
		run_stream();
		item_valid <= 1'b0;

		// drain, then a short tail for anything stray
		waited = 0;
		while (cursor_reports.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		if (cursor_reports.size() != 0) begin
			$error("%0d result items never arrived", cursor_reports.size());
			errors++;
		end
		repeat (200) @(posedge clk);

		$display("run covered %0d items, %0d results, %0d scrolls, %0d replays",
			items_sent, results_seen, scrolls, replays);
		$display("top bar off and on, directed table plus random escape traffic");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/tcew_pkg.sv
hw/rtl/tcew_ram.sv
hw/rtl/tcew_parse.sv
hw/rtl/text_console_escape_writer_core.sv
sim/text_console_escape_writer_core_tb.sv
